// ===== hdl/nac_pkg.sv =====
// ----------------------------------------------------------------------------
// nac_pkg
// Shared types, tables and round functions of the nibble AES block cipher.
// ----------------------------------------------------------------------------
package nac_pkg;

  localparam int NUM_ROUNDS_DEF = 10;
  localparam int BLOCK_W        = 64;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } nac_cmd_t;

  // one pipeline stage: item valid, direction and the running state
  typedef struct packed {
    logic                 vld;
    nac_cmd_t             dir;
    logic [BLOCK_W-1:0]   st;
  } nac_stage_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'hE;  4'h1: r = 4'h4;  4'h2: r = 4'hD;  4'h3: r = 4'h1;
      4'h4: r = 4'h2;  4'h5: r = 4'hF;  4'h6: r = 4'hB;  4'h7: r = 4'h8;
      4'h8: r = 4'h3;  4'h9: r = 4'hA;  4'hA: r = 4'h6;  4'hB: r = 4'hC;
      4'hC: r = 4'h5;  4'hD: r = 4'h9;  4'hE: r = 4'h0;  4'hF: r = 4'h7;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'hE;  4'h1: r = 4'h3;  4'h2: r = 4'h4;  4'h3: r = 4'h8;
      4'h4: r = 4'h1;  4'h5: r = 4'hC;  4'h6: r = 4'hA;  4'h7: r = 4'hF;
      4'h8: r = 4'h7;  4'h9: r = 4'hD;  4'hA: r = 4'h9;  4'hB: r = 4'h6;
      4'hC: r = 4'hB;  4'hD: r = 4'h2;  4'hE: r = 4'h0;  4'hF: r = 4'h5;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] mix_coef(input nac_cmd_t dir, input logic [1:0] idx);
    logic [3:0] c;
    case (idx)
      2'd0:    c = (dir == CMD_DECRYPT) ? 4'h8 : 4'h1;
      2'd1:    c = (dir == CMD_DECRYPT) ? 4'hC : 4'h1;
      2'd2:    c = (dir == CMD_DECRYPT) ? 4'h7 : 4'h4;
      default: c = (dir == CMD_DECRYPT) ? 4'h7 : 4'h9;
    endcase
    return c;
  endfunction

  // GF(16) multiply, polynomial x^4+x+1
  function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] sh;
    acc = 4'h0;
    sh  = a;
    for (int bit_i = 0; bit_i < 4; bit_i++) begin
      if (b[bit_i]) begin
        acc = acc ^ sh;
      end
      sh = sh[3] ? ({sh[2:0], 1'b0} ^ 4'h3) : {sh[2:0], 1'b0};
    end
    return acc;
  endfunction

  // column mix of one word, nibble 0 in the top bits
  function automatic logic [15:0] mix_col(input logic [15:0] a, input nac_cmd_t dir);
    logic [15:0] w;
    logic [3:0]  v;
    w = '0;
    for (int r = 0; r < 4; r++) begin
      v = 4'h0;
      for (int j = 0; j < 4; j++) begin
        v = v ^ gf16_mul(mix_coef(dir, 2'(r + j)), a[15-4*j -: 4]);
      end
      w[15-4*r -: 4] = v;
    end
    return w;
  endfunction

  function automatic logic [BLOCK_W-1:0] inv_mix_key(input logic [BLOCK_W-1:0] k);
    logic [BLOCK_W-1:0] km;
    for (int i = 0; i < 4; i++) begin
      km[63-16*i -: 16] = mix_col(k[63-16*i -: 16], CMD_DECRYPT);
    end
    return km;
  endfunction

  // sub nibbles, shift rows, optional column mix, key add
  function automatic logic [BLOCK_W-1:0] round_fn(input logic [BLOCK_W-1:0] st,
                                                  input nac_cmd_t dir,
                                                  input logic mix,
                                                  input logic [BLOCK_W-1:0] key);
    logic [BLOCK_W-1:0] res;
    logic [15:0]        a;
    logic [1:0]         src;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        src = (dir == CMD_DECRYPT) ? 2'(i - j) : 2'(i + j);
        a[15-4*j -: 4] = (dir == CMD_DECRYPT) ? sbox_inv(st[63-16*src-4*j -: 4])
                                              : sbox_fwd(st[63-16*src-4*j -: 4]);
      end
      res[63-16*i -: 16] = (mix ? mix_col(a, dir) : a) ^ key[63-16*i -: 16];
    end
    return res;
  endfunction

endpackage

// ===== hdl/nac_if.sv =====
// ----------------------------------------------------------------------------
// nac_if
// Handshake channels of the nibble AES block cipher: input, result, key write.
// ----------------------------------------------------------------------------
interface nac_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] block_in;
  modport source (output valid, command, block_in, input ready);
  modport sink   (input valid, command, block_in, output ready);
endinterface

interface nac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;
  modport source (output valid, block_out, input ready);
  modport sink   (input valid, block_out, output ready);
endinterface

interface nac_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_key;
  modport source (output valid, cipher_key, input ready);
  modport sink   (input valid, cipher_key, output ready);
endinterface

// ===== hdl/nac_round.sv =====
// ----------------------------------------------------------------------------
// nac_round
// One cipher round as one pipeline stage, registered at its output.
// ----------------------------------------------------------------------------
module nac_round
  import nac_pkg::*;
#(
  parameter bit LAST_ROUND = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  nac_stage_t         d,
  input  logic [BLOCK_W-1:0] key,
  input  logic [BLOCK_W-1:0] key_mix,
  output nac_stage_t         q
);

  logic               vld_r;
  nac_cmd_t           dir_r;
  logic [BLOCK_W-1:0] st_r;
  logic [BLOCK_W-1:0] rkey;
  logic [BLOCK_W-1:0] st_nxt;

  // middle decrypt rounds use the inverse-mixed key
  assign rkey   = (!LAST_ROUND && d.dir == CMD_DECRYPT) ? key_mix : key;
  assign st_nxt = round_fn(d.st, d.dir, !LAST_ROUND, rkey);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= d.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_r <= d.dir;
      st_r  <= st_nxt;
    end
  end

  assign q = '{vld: vld_r, dir: dir_r, st: st_r};

endmodule

// ===== hdl/nibble_aes_block_cipher.sv =====
// ----------------------------------------------------------------------------
// nibble_aes_block_cipher
// 64-bit nibble AES-like cipher, rounds unrolled into a stalling pipeline.
// ----------------------------------------------------------------------------
// Accepts one block per clock while not stalled. One stage registers the
// block with the initial key add, then one stage per round. The whole
// pipeline moves together and freezes while a result waits at the output
// with out_ch.ready low. The user must write the key through cfg_ch (always
// ready) only while no block is in flight; the block does not enforce this.
// The inverse-mixed key for decryption is formed and stored at the write.
module nibble_aes_block_cipher
  import nac_pkg::*;
#(
  parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nac_in_if.sink     in_ch,
  nac_out_if.source  out_ch,
  nac_cfg_if.sink    cfg_ch
);

  logic [BLOCK_W-1:0] key_r;
  logic [BLOCK_W-1:0] km_r;
  logic               adv;
  logic               s0_vld_r;
  nac_cmd_t           s0_dir_r;
  logic [BLOCK_W-1:0] s0_st_r;
  nac_stage_t         stg [NUM_ROUNDS+1];
  logic [NUM_ROUNDS:0] vld_vec;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      km_r  <= '0;
    end else if (cfg_ch.valid) begin
      key_r <= cfg_ch.cipher_key;
      km_r  <= inv_mix_key(cfg_ch.cipher_key);
    end
  end

  assign adv         = !stg[NUM_ROUNDS].vld || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dir_r <= nac_cmd_t'(in_ch.command);
      s0_st_r  <= in_ch.block_in ^ key_r;
    end
  end

  assign stg[0] = '{vld: s0_vld_r, dir: s0_dir_r, st: s0_st_r};

  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    nac_round #(
      .LAST_ROUND (g == NUM_ROUNDS - 1)
    ) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .d       (stg[g]),
      .key     (key_r),
      .key_mix (km_r),
      .q       (stg[g+1])
    );
  end

  for (genvar g = 0; g <= NUM_ROUNDS; g++) begin : g_vld
    assign vld_vec[g] = stg[g].vld;
  end

  assign out_ch.valid     = stg[NUM_ROUNDS].vld;
  assign out_ch.block_out = stg[NUM_ROUNDS].st;

  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s0_vld_r)
    else $error("accepted item missing from first stage");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_vec))
    else $error("pipeline moved while stalled");

  a_key_mix: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.ready |=> km_r == inv_mix_key(key_r))
    else $error("inverse-mixed key out of step with key");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
